[rtl/assert_macros.svh]
// Assertion helpers. They sample on aclk and are off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every edge
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("check failed: %m");

// cons holds at the same edge as ante
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("check failed: %m");

// cons holds at the edge after ante
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("check failed: %m");

`endif

[rtl/shp_pkg.sv]
package shp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam int DIM_W     = 11;
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int CFG_IDX_W = 2;

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = Q_PTR_W + 1;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic OPCODE_PIXEL = 1'b0;
    localparam logic OPCODE_DRAIN = 1'b1;

    // Work kinds passed from front to back
    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_PRIME = 2'd1,
        OP_DRAIN = 2'd2
    } shp_op_t;

    typedef struct packed {
        shp_op_t            op;
        logic [COL_W-1:0]   wr_addr;
        logic [COL_W-1:0]   rd_addr;
        logic [PIX_W-1:0]   pix;
        logic               emit_a;
        logic               emit_b;
        logic               x_first;
        logic               x_second;
        logic               x_last;
        logic               top_clamp;
    } shp_entry_t;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] pix;
    } shp_col_t;

    typedef struct packed {
        logic [PIX_W-1:0] c;
        logic [PIX_W-1:0] t;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] l;
        logic [PIX_W-1:0] r;
        logic             eor;
        logic             eof;
    } shp_taps_t;

    // Last valid index for a row or column count: zero acts as one, large values clip
    function automatic int dim_last(input logic [DIM_W-1:0] v, input int maxv);
        int n;
        n = int'(v);
        if (n < 1) n = 1;
        if (n > maxv) n = maxv;
        return n - 1;
    endfunction

    function automatic logic [CH_W-1:0] sharpen_ch(
        input logic [CH_W-1:0] c,
        input logic [CH_W-1:0] t,
        input logic [CH_W-1:0] b,
        input logic [CH_W-1:0] l,
        input logic [CH_W-1:0] r
    );
        logic [CH_W+2:0] pos;
        logic [CH_W+1:0] neg;
        logic [CH_W+2:0] diff;
        pos = (CH_W+3)'({c, 2'b00}) + (CH_W+3)'(c);
        neg = (CH_W+2)'(t) + (CH_W+2)'(b) + (CH_W+2)'(l) + (CH_W+2)'(r);
        diff = pos - (CH_W+3)'(neg);
        if (pos <= (CH_W+3)'(neg)) begin
            return '0;
        end else if (diff > (CH_W+3)'({CH_W{1'b1}})) begin
            return {CH_W{1'b1}};
        end else begin
            return diff[CH_W-1:0];
        end
    endfunction

    function automatic logic [PIX_W-1:0] sharpen_pix(input shp_taps_t tp);
        logic [PIX_W-1:0] res;
        for (int k = 0; k < 3; k++) begin
            res[k*CH_W +: CH_W] = sharpen_ch(tp.c[k*CH_W +: CH_W], tp.t[k*CH_W +: CH_W],
                                             tp.b[k*CH_W +: CH_W], tp.l[k*CH_W +: CH_W],
                                             tp.r[k*CH_W +: CH_W]);
        end
        return res;
    endfunction

endpackage

[rtl/shp_ram.sv]
module shp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             re,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (re) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/shp_front.sv]
`include "assert_macros.svh"

module shp_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [shp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [shp_pkg::DIM_W-1:0]        cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [shp_pkg::CH_W-1:0]         s_in_red,
    input  logic [shp_pkg::CH_W-1:0]         s_in_green,
    input  logic [shp_pkg::CH_W-1:0]         s_in_blue,
    output logic                             q_push,
    output shp_pkg::shp_entry_t              q_entry,
    input  logic                             q_ready
);

    import shp_pkg::*;

    logic [COL_W-1:0] wm1_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] hm1_reg;
    logic [ROW_W-1:0] row_reg;
    logic             draining_reg;
    logic             prime_pend_reg;

    logic cfg_fire;
    logic s_fire;
    logic is_drain;
    logic x_last;
    logic row_last;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_ready   = q_ready && !prime_pend_reg;
    assign s_fire    = s_valid && s_ready;
    assign is_drain  = (s_opcode == OPCODE_DRAIN);
    assign x_last    = (col_reg == wm1_reg);
    assign row_last  = (row_reg >= hm1_reg);

    always_comb begin
        q_entry.op        = OP_PIXEL;
        q_entry.wr_addr   = col_reg;
        q_entry.rd_addr   = col_reg;
        q_entry.pix       = {s_in_red, s_in_green, s_in_blue};
        q_entry.emit_a    = (row_reg != '0) && (col_reg != '0);
        q_entry.emit_b    = (row_reg != '0) && x_last;
        q_entry.x_first   = (col_reg == '0);
        q_entry.x_second  = (col_reg == COL_W'(1));
        q_entry.x_last    = x_last;
        q_entry.top_clamp = (row_reg == ROW_W'(1));
        q_push            = 1'b0;
        if (prime_pend_reg) begin
            // preload column zero of the stored rows ahead of the drain
            q_entry.op      = OP_PRIME;
            q_entry.rd_addr = '0;
            q_push          = q_ready;
        end else if (s_fire && is_drain && draining_reg) begin
            q_entry.op        = OP_DRAIN;
            q_entry.rd_addr   = x_last ? col_reg : col_reg + COL_W'(1);
            q_entry.top_clamp = (hm1_reg == '0);
            q_push            = 1'b1;
        end else if (s_fire && !is_drain && !draining_reg) begin
            q_push = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wm1_reg        <= COL_W'(dim_last(DIM_RESET, MAX_WIDTH));
            hm1_reg        <= ROW_W'(dim_last(DIM_RESET, MAX_HEIGHT));
            col_reg        <= '0;
            row_reg        <= '0;
            draining_reg   <= 1'b0;
            prime_pend_reg <= 1'b0;
        end else if (cfg_fire) begin
            if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT) begin
                if (cfg_index == REG_IMAGE_WIDTH) begin
                    wm1_reg <= COL_W'(dim_last(cfg_data, MAX_WIDTH));
                end else begin
                    hm1_reg <= ROW_W'(dim_last(cfg_data, MAX_HEIGHT));
                end
                // restart the frame
                col_reg        <= '0;
                row_reg        <= '0;
                draining_reg   <= 1'b0;
                prime_pend_reg <= 1'b0;
            end
        end else begin
            if (prime_pend_reg && q_ready) begin
                prime_pend_reg <= 1'b0;
            end
            if (s_fire && !is_drain && !draining_reg) begin
                if (x_last) begin
                    col_reg <= '0;
                    if (row_last) begin
                        draining_reg   <= 1'b1;
                        prime_pend_reg <= 1'b1;
                    end else begin
                        row_reg <= row_reg + ROW_W'(1);
                    end
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end else if (s_fire && is_drain && draining_reg) begin
                if (x_last) begin
                    col_reg      <= '0;
                    row_reg      <= '0;
                    draining_reg <= 1'b0;
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    `ASSERT_ALWAYS(a_col_in_row, col_reg <= wm1_reg)
    `ASSERT_IMPLIES(a_prime_in_drain, prime_pend_reg, draining_reg && !s_ready)

endmodule

[rtl/shp_queue.sv]
`include "assert_macros.svh"

module shp_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  shp_pkg::shp_entry_t  push_entry,
    output logic                 push_ready,
    input  logic                 pop,
    output shp_pkg::shp_entry_t  head,
    output logic                 head_valid
);

    import shp_pkg::*;

    shp_entry_t         entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

    `ASSERT_ALWAYS(a_q_count, count_reg <= Q_CNT_W'(Q_DEPTH))

endmodule

[rtl/shp_back.sv]
`include "assert_macros.svh"

module shp_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  shp_pkg::shp_entry_t       q_head,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [shp_pkg::CH_W-1:0]  m_out_red,
    output logic [shp_pkg::CH_W-1:0]  m_out_green,
    output logic [shp_pkg::CH_W-1:0]  m_out_blue,
    output logic                      m_end_of_row,
    output logic                      m_end_of_frame
);

    import shp_pkg::*;

    // item stage: line store data arrives here
    shp_entry_t       b_reg;
    logic             b_valid_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_l1_reg;
    logic [PIX_W-1:0] fwd_l2_reg;

    // window: previous column and the mid row of the one before it
    shp_col_t         w1_reg;
    logic [PIX_W-1:0] w0_mid_reg;

    // result slots and output register
    shp_taps_t        slot_a_reg;
    shp_taps_t        slot_b_reg;
    logic             ca_reg;
    logic             cb_reg;
    logic             m_valid_reg;
    logic [PIX_W-1:0] out_pix_reg;
    logic             eor_reg;
    logic             eof_reg;

    logic [PIX_W-1:0] ram1_q;
    logic [PIX_W-1:0] ram2_q;
    logic [PIX_W-1:0] l1;
    logic [PIX_W-1:0] l2;
    shp_taps_t        taps_a;
    shp_taps_t        taps_b;
    shp_taps_t        taps_d;
    shp_taps_t        sel;
    logic             b_pixel;
    logic             b_drain;
    logic             b_res;
    logic             out_free;
    logic             send_a;
    logic             send_b;
    logic             c_take;
    logic             adv;
    logic             wr_en;
    logic             fwd_hit;

    assign b_pixel = b_valid_reg && (b_reg.op == OP_PIXEL);
    assign b_drain = b_valid_reg && (b_reg.op == OP_DRAIN);
    assign b_res   = b_drain || (b_pixel && (b_reg.emit_a || b_reg.emit_b));

    assign out_free = !m_valid_reg || m_ready;
    assign send_a   = out_free && ca_reg;
    assign send_b   = out_free && !ca_reg && cb_reg;
    assign c_take   = (!ca_reg && !cb_reg) || (out_free && (ca_reg ^ cb_reg));
    assign adv      = !b_res || c_take;
    assign q_pop    = adv && q_valid;
    assign wr_en    = adv && b_pixel;
    assign fwd_hit  = wr_en && q_pop && (q_head.rd_addr == b_reg.wr_addr);

    shp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_one (
        .clk     (aclk),
        .we      (wr_en),
        .wr_addr (b_reg.wr_addr),
        .wr_data (b_reg.pix),
        .re      (q_pop),
        .rd_addr (q_head.rd_addr),
        .rd_data (ram1_q)
    );

    shp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_two (
        .clk     (aclk),
        .we      (wr_en),
        .wr_addr (b_reg.wr_addr),
        .wr_data (l1),
        .re      (q_pop),
        .rd_addr (q_head.rd_addr),
        .rd_data (ram2_q)
    );

    // take the word written in the same cycle as the read
    assign l1 = fwd_reg ? fwd_l1_reg : ram1_q;
    assign l2 = fwd_reg ? fwd_l2_reg : ram2_q;

    always_comb begin
        // previous column, done now that its right neighbor is here
        taps_a.c   = w1_reg.mid;
        taps_a.t   = b_reg.top_clamp ? w1_reg.mid : w1_reg.top;
        taps_a.b   = w1_reg.pix;
        taps_a.l   = b_reg.x_second ? w1_reg.mid : w0_mid_reg;
        taps_a.r   = l1;
        taps_a.eor = 1'b0;
        taps_a.eof = 1'b0;

        // last column of the row
        taps_b.c   = l1;
        taps_b.t   = b_reg.top_clamp ? l1 : l2;
        taps_b.b   = b_reg.pix;
        taps_b.l   = b_reg.x_first ? l1 : w1_reg.mid;
        taps_b.r   = l1;
        taps_b.eor = 1'b1;
        taps_b.eof = 1'b0;

        // bottom row, mirrored below itself
        taps_d.c   = w1_reg.mid;
        taps_d.t   = b_reg.top_clamp ? w1_reg.mid : w1_reg.top;
        taps_d.b   = w1_reg.mid;
        taps_d.l   = b_reg.x_first ? w1_reg.mid : w0_mid_reg;
        taps_d.r   = b_reg.x_last ? w1_reg.mid : l1;
        taps_d.eor = b_reg.x_last;
        taps_d.eof = b_reg.x_last;
    end

    assign sel = ca_reg ? slot_a_reg : slot_b_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_reg      <= q_head;
            fwd_l1_reg <= b_reg.pix;
            fwd_l2_reg <= l1;
        end
        if (adv && b_valid_reg) begin
            w0_mid_reg <= w1_reg.mid;
            w1_reg.top <= l2;
            w1_reg.mid <= l1;
            w1_reg.pix <= b_reg.pix;
        end
        if (adv && b_res) begin
            slot_a_reg <= b_drain ? taps_d : taps_a;
            slot_b_reg <= taps_b;
        end
        if (out_free && (ca_reg || cb_reg)) begin
            out_pix_reg <= sharpen_pix(sel);
            eor_reg     <= sel.eor;
            eof_reg     <= sel.eof;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            ca_reg      <= 1'b0;
            cb_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                b_valid_reg <= q_pop;
                fwd_reg     <= fwd_hit;
            end
            if (adv && b_res) begin
                ca_reg <= b_drain || b_reg.emit_a;
                cb_reg <= b_pixel && b_reg.emit_b;
            end else begin
                if (send_a) begin
                    ca_reg <= 1'b0;
                end
                if (send_b) begin
                    cb_reg <= 1'b0;
                end
            end
            if (out_free) begin
                m_valid_reg <= ca_reg || cb_reg;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_red      = out_pix_reg[2*CH_W +: CH_W];
    assign m_out_green    = out_pix_reg[CH_W +: CH_W];
    assign m_out_blue     = out_pix_reg[0 +: CH_W];
    assign m_end_of_row   = eor_reg;
    assign m_end_of_frame = eof_reg;

    `ASSERT_IMPLIES(a_fwd_has_item, fwd_reg, b_valid_reg)
    `ASSERT_NEXT(a_slots_hold, ca_reg && cb_reg && m_valid_reg && !m_ready, ca_reg && cb_reg)
    `ASSERT_IMPLIES(a_drain_one_slot, adv && b_drain, !(b_pixel))

endmodule

[rtl/sharpen_3x3_stencil_rgb.sv]
// 3x3 Laplacian sharpen (5*centre minus the four direct neighbours, clamped edges,
// saturated to 0..255) on an RGB pixel stream in raster order. The block takes one
// item per clock while s_ready is high: a front stage tracks column and row and
// classifies each item, a four-entry queue feeds the back stage, which reads two
// 1024x24 line stores (one write and one read port each) once per item and keeps a
// two-column window in registers. The result for pixel (x, y) leaves when pixel
// (x+1, y+1) arrives; on rows after the first, the last pixel also yields the result
// for the pixel above it. After the last pixel of a frame s_ready drops (longer
// while the queue is full) as the back stage preloads column zero of the stored
// rows; image_width drain items (opcode 1) then emit the last row, the final
// one flagged end_of_row and end_of_frame. Items that do not fit the current
// phase are taken and dropped. cfg_ready is always high;
// a write to image_width or image_height restarts the frame and must be made while
// the block is idle. Line store entries are never cleared and need no init pass.
module sharpen_3x3_stencil_rgb (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [shp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [shp_pkg::DIM_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [shp_pkg::CH_W-1:0]      s_in_red,
    input  logic [shp_pkg::CH_W-1:0]      s_in_green,
    input  logic [shp_pkg::CH_W-1:0]      s_in_blue,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [shp_pkg::CH_W-1:0]      m_out_red,
    output logic [shp_pkg::CH_W-1:0]      m_out_green,
    output logic [shp_pkg::CH_W-1:0]      m_out_blue,
    output logic                          m_end_of_row,
    output logic                          m_end_of_frame
);

    import shp_pkg::*;

    logic       q_push;
    shp_entry_t q_entry;
    logic       q_ready;
    logic       q_pop;
    shp_entry_t q_head;
    logic       q_valid;

    shp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_in_red   (s_in_red),
        .s_in_green (s_in_green),
        .s_in_blue  (s_in_blue),
        .q_push     (q_push),
        .q_entry    (q_entry),
        .q_ready    (q_ready)
    );

    shp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_valid)
    );

    shp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue),
        .m_end_of_row   (m_end_of_row),
        .m_end_of_frame (m_end_of_frame)
    );

endmodule
